// File: hw/rtl/dtrg_pkg.sv
`default_nettype none

package dtrg_pkg;

  // quarter-wave sine table
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SINE_LOG2        = $clog2(SINE_TABLE_DEPTH);
  localparam int TBL_ENTRIES      = SINE_TABLE_DEPTH + 1;
  localparam int TBL_AW           = $clog2(TBL_ENTRIES);
  localparam int SINE_W           = 16;

  // output saturation width
  localparam int SAMPLE_BITS      = 16;
  localparam int OUT_W            = 16;

  // APB register file
  localparam int CFG_AW           = 5;
  localparam int CFG_DW           = 32;

  typedef enum logic [2:0] {
    REG_TONE1_STEP = 3'd0,
    REG_TONE2_STEP = 3'd1,
    REG_CYCLE_LEN  = 3'd2,
    REG_TONE_LEN   = 3'd3,
    REG_FADE_STEP  = 3'd4,
    REG_AMPLITUDE  = 3'd5
  } cfg_reg_t;

  localparam logic [31:0] TONE1_STEP_RST = 32'd39370534;
  localparam logic [31:0] TONE2_STEP_RST = 32'd42949673;
  localparam logic [19:0] CYCLE_LEN_RST  = 20'd288000;
  localparam logic [19:0] TONE_LEN_RST   = 20'd96000;
  localparam logic [16:0] FADE_STEP_RST  = 17'd137;
  localparam logic [13:0] AMPLITUDE_RST  = 14'd6553;

  // Q30 odd polynomial for sin(pi/2 * u)
  localparam logic [31:0] CO1 = 32'd1686629713;
  localparam logic [31:0] CO3 = 32'd693598668;
  localparam logic [31:0] CO5 = 32'd85569306;
  localparam logic [31:0] CO7 = 32'd5026995;
  localparam logic [31:0] CO9 = 32'd172272;

  localparam logic [15:0] FULL_SINE = 16'd32767;
  localparam logic [16:0] FADE_FULL = 17'd65536;

endpackage

`default_nettype wire

// File: hw/rtl/dtrg_ram.sv
`default_nettype none

module dtrg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1025
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: hw/rtl/dual_tone_ring_generator.sv
`default_nettype none

// Channel   Ports                                         Direction  Moves
// input     in_valid, in_stall, in_restart                 in         one sample tick
// output    out_valid, out_stall, out_sample,              out        one audio sample
//           out_tone_active
// config    psel, penable, pwrite, paddr, pwdata,          in/out     register write/read
//           prdata, pready
//
// A tone sample's time from accept to the next accept is set by the radix-16
// serial multiplier (4 digits for amplitude, 5 for fade) and two reads of the
// sine RAM; a silent one skips both. After reset the RAM is filled by the same
// multiplier, one entry of SINE_TABLE_DEPTH+1 after another; in_stall stays high
// meanwhile. Reset is synchronous, active low. A result waits in the output
// register while the next transaction is worked on.

module dual_tone_ring_generator (
  input  wire                             clk,
  input  wire                             rst_n,
  // input channel
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire                             in_restart,
  // output channel
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic signed [dtrg_pkg::OUT_W-1:0] out_sample,
  output logic                            out_tone_active,
  // APB config
  input  wire                             psel,
  input  wire                             penable,
  input  wire                             pwrite,
  input  wire [dtrg_pkg::CFG_AW-1:0]      paddr,
  input  wire [dtrg_pkg::CFG_DW-1:0]      pwdata,
  output logic [dtrg_pkg::CFG_DW-1:0]     prdata,
  output logic                            pready
);

  localparam int TBL_AW    = dtrg_pkg::TBL_AW;
  localparam int SINE_LOG2 = dtrg_pkg::SINE_LOG2;
  localparam int U_SH      = 30 - SINE_LOG2;          // k -> Q30 argument
  localparam int MUL_CW    = 4;                       // digit counter width
  localparam logic [MUL_CW-1:0] DIG_FULL = 4'd8;      // 32-bit multiplier operand
  localparam logic [MUL_CW-1:0] DIG_AMP  = MUL_CW'((14 + 3) / 4);
  localparam logic [MUL_CW-1:0] DIG_FADE = MUL_CW'((17 + 3) / 4);
  localparam logic [24:0] SAT_POS = 25'((64'd1 << (dtrg_pkg::SAMPLE_BITS - 1)) - 1);
  localparam logic [32:0] DIV_K   = 33'd32767;
  localparam logic [63:0] Q30_HALF = 64'd1 << 29;

  // table fill steps
  localparam logic [2:0] FOP_SQUARE    = 3'd0;
  localparam logic [2:0] FOP_POLY_LAST = 3'd4;
  localparam logic [2:0] FOP_SCALE     = 3'd5;
  localparam logic [2:0] FOP_ROUND     = 3'd6;

  typedef enum logic [11:0] {
    S_FILL_START = 12'b0000_0000_0001,
    S_FILL_MUL   = 12'b0000_0000_0010,
    S_IDLE       = 12'b0000_0000_0100,
    S_SETUP      = 12'b0000_0000_1000,
    S_RD1        = 12'b0000_0001_0000,
    S_RD2        = 12'b0000_0010_0000,
    S_SUM        = 12'b0000_0100_0000,
    S_MUL1       = 12'b0000_1000_0000,
    S_MUL2       = 12'b0001_0000_0000,
    S_FIX        = 12'b0010_0000_0000,
    S_DONE       = 12'b0100_0000_0000
  } state_t;

  // ---------------------------------------------------------------- config
  logic [31:0] tone1_step_r, tone2_step_r;
  logic [19:0] cycle_len_r, tone_len_r;
  logic [16:0] fade_step_r;
  logic [13:0] amplitude_r;
  logic        cfg_wr;
  dtrg_pkg::cfg_reg_t cfg_idx;

  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = dtrg_pkg::cfg_reg_t'(paddr[dtrg_pkg::CFG_AW-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone1_step_r <= dtrg_pkg::TONE1_STEP_RST;
      tone2_step_r <= dtrg_pkg::TONE2_STEP_RST;
      cycle_len_r  <= dtrg_pkg::CYCLE_LEN_RST;
      tone_len_r   <= dtrg_pkg::TONE_LEN_RST;
      fade_step_r  <= dtrg_pkg::FADE_STEP_RST;
      amplitude_r  <= dtrg_pkg::AMPLITUDE_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        dtrg_pkg::REG_TONE1_STEP: tone1_step_r <= pwdata;
        dtrg_pkg::REG_TONE2_STEP: tone2_step_r <= pwdata;
        dtrg_pkg::REG_CYCLE_LEN:  cycle_len_r  <= pwdata[19:0];
        dtrg_pkg::REG_TONE_LEN:   tone_len_r   <= pwdata[19:0];
        dtrg_pkg::REG_FADE_STEP:  fade_step_r  <= pwdata[16:0];
        dtrg_pkg::REG_AMPLITUDE:  amplitude_r  <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      dtrg_pkg::REG_TONE1_STEP: prdata = tone1_step_r;
      dtrg_pkg::REG_TONE2_STEP: prdata = tone2_step_r;
      dtrg_pkg::REG_CYCLE_LEN:  prdata = {12'd0, cycle_len_r};
      dtrg_pkg::REG_TONE_LEN:   prdata = {12'd0, tone_len_r};
      dtrg_pkg::REG_FADE_STEP:  prdata = {15'd0, fade_step_r};
      dtrg_pkg::REG_AMPLITUDE:  prdata = {18'd0, amplitude_r};
      default:                  prdata = '0;
    endcase
  end

  // ------------------------------------------------------------- sine RAM
  logic                          tbl_we;
  logic [TBL_AW-1:0]             tbl_waddr, tbl_raddr;
  logic [dtrg_pkg::SINE_W-1:0]   tbl_wdata, tbl_rdata;

  dtrg_ram #(
    .WIDTH (dtrg_pkg::SINE_W),
    .DEPTH (dtrg_pkg::TBL_ENTRIES)
  ) u_sine_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // phase -> table address, folding the odd quadrants
  function automatic logic [TBL_AW-1:0] sine_addr(input logic [31:0] ph);
    logic [SINE_LOG2-1:0] off;
    off = ph[29 -: SINE_LOG2];
    if (ph[30]) begin
      sine_addr = TBL_AW'(dtrg_pkg::SINE_TABLE_DEPTH) - TBL_AW'(off);
    end else begin
      sine_addr = TBL_AW'(off);
    end
  endfunction

  function automatic logic [31:0] poly_coef(input logic [2:0] op);
    case (op)
      3'd1:    poly_coef = dtrg_pkg::CO7;
      3'd2:    poly_coef = dtrg_pkg::CO5;
      3'd3:    poly_coef = dtrg_pkg::CO3;
      default: poly_coef = dtrg_pkg::CO1;
    endcase
  endfunction

  // ------------------------------------------ radix-16 serial multiplier
  // One 4-bit digit of b per cycle, LSB first; the partial product is
  // four shifted copies of a. mul_done_r pulses the cycle after the last
  // digit, when mul_acc_r holds the full product.
  logic              mul_start;
  logic [31:0]       mul_a_in, mul_b_in;
  logic [MUL_CW-1:0] mul_dig_in;
  logic [63:0]       mul_a_r, mul_acc_r, mul_pp;
  logic [31:0]       mul_b_r;
  logic [MUL_CW-1:0] mul_cnt_r;
  logic              mul_busy_r, mul_done_r;

  assign mul_pp = (mul_b_r[0] ? mul_a_r        : 64'd0)
                + (mul_b_r[1] ? mul_a_r << 1   : 64'd0)
                + (mul_b_r[2] ? mul_a_r << 2   : 64'd0)
                + (mul_b_r[3] ? mul_a_r << 3   : 64'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_busy_r <= 1'b0;
      mul_done_r <= 1'b0;
      mul_cnt_r  <= '0;
    end else begin
      mul_done_r <= mul_busy_r && (mul_cnt_r == MUL_CW'(1));
      if (mul_start) begin
        mul_busy_r <= 1'b1;
        mul_cnt_r  <= mul_dig_in;
      end else if (mul_busy_r) begin
        mul_cnt_r <= mul_cnt_r - MUL_CW'(1);
        if (mul_cnt_r == MUL_CW'(1)) begin
          mul_busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_start) begin
      mul_acc_r <= '0;
      mul_a_r   <= {32'd0, mul_a_in};
      mul_b_r   <= mul_b_in;
    end else if (mul_busy_r) begin
      mul_acc_r <= mul_acc_r + mul_pp;
      mul_a_r   <= mul_a_r << 4;
      mul_b_r   <= mul_b_r >> 4;
    end
  end

  // ------------------------------------------------------------ sequencer
  state_t state_r, state_nxt;
  logic [TBL_AW-1:0] k_r, k_nxt;
  logic [2:0]  op_r, op_nxt;
  logic [31:0] u_r, u_nxt, u2_r, u2_nxt;

  logic        restart_r, restart_nxt;
  logic [19:0] pos_r, pos_nxt;
  logic [31:0] phase_one_r, phase_one_nxt, phase_two_r, phase_two_nxt;
  logic [16:0] fade_r, fade_nxt;

  logic [31:0] ph1_w_r, ph1_w_nxt, ph2_w_r, ph2_w_nxt;
  logic [16:0] fade_w_r, fade_w_nxt;
  logic        active_r, active_nxt;
  logic signed [16:0] sine1_r, sine1_nxt;
  logic        neg_r, neg_nxt;
  logic [30:0] x_r, x_nxt;
  logic [16:0] q0_r, q0_nxt;
  logic [15:0] res_r, res_nxt;

  logic        out_valid_r, out_valid_nxt, out_tone_active_r, out_tone_active_nxt;
  logic [15:0] out_sample_r, out_sample_nxt;

  // helpers
  logic [31:0] p_hi, coef_s;
  logic [16:0] p_round;
  logic [19:0] pos_c;
  logic [20:0] pos_inc;
  logic        cyc_start;
  logic [17:0] fade_sum;
  logic signed [16:0] sine2;
  logic signed [17:0] sum;
  logic [15:0] mag;
  logic [31:0] div_est;
  logic [32:0] div_r;
  logic [17:0] q_fix;
  logic [24:0] q_ext, q_lim;
  logic [24:0] res_ext;

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_sample      = out_sample_r;
  assign out_tone_active = out_tone_active_r;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    op_nxt        = op_r;
    u_nxt         = u_r;
    u2_nxt        = u2_r;
    restart_nxt   = restart_r;
    pos_nxt       = pos_r;
    phase_one_nxt = phase_one_r;
    phase_two_nxt = phase_two_r;
    fade_nxt      = fade_r;
    ph1_w_nxt     = ph1_w_r;
    ph2_w_nxt     = ph2_w_r;
    fade_w_nxt    = fade_w_r;
    active_nxt    = active_r;
    sine1_nxt     = sine1_r;
    neg_nxt       = neg_r;
    x_nxt         = x_r;
    q0_nxt        = q0_r;
    res_nxt       = res_r;

    out_valid_nxt       = out_valid_r & out_stall;
    out_sample_nxt      = out_sample_r;
    out_tone_active_nxt = out_tone_active_r;

    mul_start  = 1'b0;
    mul_a_in   = '0;
    mul_b_in   = '0;
    mul_dig_in = '0;
    tbl_we     = 1'b0;
    tbl_waddr  = k_r;
    tbl_wdata  = '0;
    tbl_raddr  = '0;

    p_hi      = mul_acc_r[61:30];
    coef_s    = poly_coef(op_r) - p_hi;
    p_round   = 17'((mul_acc_r + Q30_HALF) >> 30);

    pos_c     = restart_r ? 20'd0 : pos_r;
    if (pos_c >= cycle_len_r) begin
      pos_c = 20'd0;
    end
    cyc_start = (pos_c == 20'd0);
    pos_inc   = {1'b0, pos_c} + 21'd1;
    fade_sum  = {1'b0, (cyc_start ? 17'd0 : fade_r)} + {1'b0, fade_step_r};

    sine2 = ph2_w_r[31] ? -$signed({1'b0, tbl_rdata}) : $signed({1'b0, tbl_rdata});
    sum   = 18'(sine1_r) + 18'(sine2);
    mag   = sum[17] ? 16'(-sum) : 16'(sum);

    div_est = {1'b0, mul_acc_r[46:16]} + 32'(mul_acc_r[46:31]) + 32'(mul_acc_r[46]);
    div_r = {2'b0, x_r} + 33'(q0_r) - (33'(q0_r) << 15);
    q_fix = (div_r >= DIV_K) ? 18'(q0_r) + 18'd1 : 18'(q0_r);
    q_ext = 25'(q_fix);
    if (neg_r) begin
      q_lim   = (q_ext > SAT_POS + 25'd1) ? SAT_POS + 25'd1 : q_ext;
      res_ext = -q_lim;
    end else begin
      q_lim   = (q_ext > SAT_POS) ? SAT_POS : q_ext;
      res_ext = q_lim;
    end

    case (state_r)
      S_FILL_START: begin
        u_nxt      = 32'(k_r) << U_SH;
        mul_start  = 1'b1;
        mul_a_in   = 32'(k_r) << U_SH;
        mul_b_in   = 32'(k_r) << U_SH;
        mul_dig_in = DIG_FULL;
        op_nxt     = FOP_SQUARE;
        state_nxt  = S_FILL_MUL;
      end
      S_FILL_MUL: begin
        if (mul_done_r) begin
          op_nxt     = op_r + 3'd1;
          mul_dig_in = DIG_FULL;
          if (op_r == FOP_SQUARE) begin
            u2_nxt    = p_hi;
            mul_start = 1'b1;
            mul_a_in  = p_hi;
            mul_b_in  = dtrg_pkg::CO9;
          end else if (op_r < FOP_POLY_LAST) begin
            mul_start = 1'b1;
            mul_a_in  = u2_r;
            mul_b_in  = coef_s;
          end else if (op_r == FOP_POLY_LAST) begin
            mul_start = 1'b1;
            mul_a_in  = u_r;
            mul_b_in  = coef_s;
          end else if (op_r == FOP_SCALE) begin
            mul_start = 1'b1;
            mul_a_in  = p_hi;
            mul_b_in  = 32'(dtrg_pkg::FULL_SINE);
          end else begin
            // FOP_ROUND: round, clamp, store
            tbl_we    = 1'b1;
            tbl_wdata = (p_round > 17'(dtrg_pkg::FULL_SINE)) ? dtrg_pkg::FULL_SINE
                                                             : p_round[15:0];
            if (k_r == TBL_AW'(dtrg_pkg::SINE_TABLE_DEPTH)) begin
              state_nxt = S_IDLE;
            end else begin
              k_nxt     = k_r + TBL_AW'(1);
              state_nxt = S_FILL_START;
            end
          end
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          restart_nxt = in_restart;
          state_nxt   = S_SETUP;
        end
      end
      S_SETUP: begin
        ph1_w_nxt     = cyc_start ? 32'd0 : phase_one_r;
        ph2_w_nxt     = cyc_start ? 32'd0 : phase_two_r;
        fade_w_nxt    = cyc_start ? 17'd0 : fade_r;
        phase_one_nxt = (cyc_start ? 32'd0 : phase_one_r) + tone1_step_r;
        phase_two_nxt = (cyc_start ? 32'd0 : phase_two_r) + tone2_step_r;
        fade_nxt      = (fade_sum > {1'b0, dtrg_pkg::FADE_FULL}) ? dtrg_pkg::FADE_FULL
                                                                 : fade_sum[16:0];
        pos_nxt       = (pos_inc >= {1'b0, cycle_len_r}) ? 20'd0 : pos_inc[19:0];
        active_nxt    = (pos_c < tone_len_r);
        res_nxt       = '0;
        state_nxt     = (pos_c < tone_len_r) ? S_RD1 : S_DONE;
      end
      S_RD1: begin
        tbl_raddr = sine_addr(ph1_w_r);
        state_nxt = S_RD2;
      end
      S_RD2: begin
        tbl_raddr = sine_addr(ph2_w_r);
        sine1_nxt = ph1_w_r[31] ? -$signed({1'b0, tbl_rdata}) : $signed({1'b0, tbl_rdata});
        state_nxt = S_SUM;
      end
      S_SUM: begin
        neg_nxt    = sum[17];
        mul_start  = 1'b1;
        mul_a_in   = 32'(mag);
        mul_b_in   = 32'(amplitude_r);
        mul_dig_in = DIG_AMP;
        state_nxt  = S_MUL1;
      end
      S_MUL1: begin
        if (mul_done_r) begin
          mul_start  = 1'b1;
          mul_a_in   = 32'(mul_acc_r[29:0]);
          mul_b_in   = 32'(fade_w_r);
          mul_dig_in = DIG_FADE;
          state_nxt  = S_MUL2;
        end
      end
      S_MUL2: begin
        // x / 32767 ~ (x + x>>15 + x>>30) >> 15, low by at most one
        if (mul_done_r) begin
          x_nxt     = mul_acc_r[46:16];
          q0_nxt    = div_est[31:15];
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        res_nxt   = res_ext[15:0];
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt       = 1'b1;
          out_sample_nxt      = res_r;
          out_tone_active_nxt = active_r;
          state_nxt           = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL_START;
      k_r         <= '0;
      op_r        <= FOP_SQUARE;
      pos_r       <= '0;
      phase_one_r <= '0;
      phase_two_r <= '0;
      fade_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      op_r        <= op_nxt;
      pos_r       <= pos_nxt;
      phase_one_r <= phase_one_nxt;
      phase_two_r <= phase_two_nxt;
      fade_r      <= fade_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    u_r               <= u_nxt;
    u2_r              <= u2_nxt;
    restart_r         <= restart_nxt;
    ph1_w_r           <= ph1_w_nxt;
    ph2_w_r           <= ph2_w_nxt;
    fade_w_r          <= fade_w_nxt;
    active_r          <= active_nxt;
    sine1_r           <= sine1_nxt;
    neg_r             <= neg_nxt;
    x_r               <= x_nxt;
    q0_r              <= q0_nxt;
    res_r             <= res_nxt;
    out_sample_r      <= out_sample_nxt;
    out_tone_active_r <= out_tone_active_nxt;
  end

endmodule

`default_nettype wire

// File: hw/rtl/dtrg_checker.sv
`default_nettype none

module dtrg_checker (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                in_valid,
  input wire                                in_stall,
  input wire                                out_valid,
  input wire                                out_stall,
  input wire signed [dtrg_pkg::OUT_W-1:0]   out_sample,
  input wire                                out_tone_active
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample) && $stable(out_tone_active))
    else $error("output transaction changed while stalled");

  // silent part of the cadence is zero
  a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tone_active |-> out_sample == '0)
    else $error("nonzero sample outside tone");

  // one transaction in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second input taken while working");

  // a new result frees the input side
  a_ready_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("input still stalled after result was posted");

endmodule

bind dual_tone_ring_generator dtrg_checker u_dtrg_checker (.*);

`default_nettype wire

// File: dv/dtrg_sample_checker.sv
`timescale 1ns / 100ps

module dtrg_sample_checker (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  input  wire                                in_stall,
  input  wire                                in_restart,
  input  wire                                out_valid,
  input  wire                                out_stall,
  input  wire signed [dtrg_pkg::OUT_W-1:0]   out_sample,
  input  wire                                out_tone_active,
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire                                pready,
  input  wire        [dtrg_pkg::CFG_AW-1:0]  paddr,
  input  wire        [dtrg_pkg::CFG_DW-1:0]  pwdata,
  output int                                 mismatches,
  output int                                 outstanding
);

  import dtrg_pkg::*;

  typedef struct packed {
    logic signed [OUT_W-1:0] sample;
    logic                    tone_active;
  } tone_sample_t;

  // register copies
  logic [31:0] tone1_inc, tone2_inc;
  logic [19:0] period, tone_span;
  logic [16:0] fade_inc;
  logic [13:0] peak;

  // cadence / oscillator state
  logic [19:0] position;
  logic [31:0] phase1, phase2;
  logic [16:0] fade;

  logic [15:0] quarter_wave [0:SINE_TABLE_DEPTH];

  tone_sample_t expected_samples [$];

  // round(32767 * sin(pi/2 * k/DEPTH)) via Q30 odd polynomial
  function automatic logic [15:0] quarter_entry(input int unsigned k);
    longint unsigned u, u2, s, v;
    u  = (64'(k) << 30) / 64'(SINE_TABLE_DEPTH);
    u2 = (u * u) >> 30;
    s  = 64'(CO9);
    s  = 64'(CO7) - ((u2 * s) >> 30);
    s  = 64'(CO5) - ((u2 * s) >> 30);
    s  = 64'(CO3) - ((u2 * s) >> 30);
    s  = 64'(CO1) - ((u2 * s) >> 30);
    v  = (u * s) >> 30;
    v  = (v * 64'(FULL_SINE) + (64'd1 << 29)) >> 30;
    if (v > 64'(FULL_SINE)) v = 64'(FULL_SINE);
    return v[15:0];
  endfunction

  function automatic int sine_at(input logic [31:0] phase);
    longint unsigned idx, quad, off;
    int v;
    idx  = (64'(phase) * 64'(4 * SINE_TABLE_DEPTH)) >> 32;
    quad = (idx / SINE_TABLE_DEPTH) & 64'd3;
    off  = idx % SINE_TABLE_DEPTH;
    if (quad[0]) v = int'(quarter_wave[SINE_TABLE_DEPTH - off]);
    else v = int'(quarter_wave[off]);
    return quad[1] ? -v : v;
  endfunction

  // one sample tick: returns the expected result and advances the state
  function automatic tone_sample_t predict_sample(input logic restart);
    tone_sample_t     r;
    int               tone_sum, fade_sum;
    longint unsigned  mag, q;
    longint           level, sat_hi, sat_lo;
    logic [20:0]      nxt;
    sat_hi = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    sat_lo = -sat_hi - 1;
    if (restart) position = '0;
    if (position >= period) position = '0;
    if (position == '0) begin
      phase1 = '0;
      phase2 = '0;
      fade   = '0;
    end
    r.tone_active = (position < tone_span);
    level = 0;
    if (r.tone_active) begin
      tone_sum = sine_at(phase1) + sine_at(phase2);
      mag = (tone_sum < 0) ? 64'(-tone_sum) : 64'(tone_sum);
      q = (mag * 64'(peak) * 64'(fade)) / (64'(FULL_SINE) << 16);
      level = (tone_sum < 0) ? -longint'(q) : longint'(q);
      if (level > sat_hi) level = sat_hi;
      if (level < sat_lo) level = sat_lo;
    end
    r.sample = level[OUT_W-1:0];
    phase1 = phase1 + tone1_inc;
    phase2 = phase2 + tone2_inc;
    fade_sum = int'(fade) + int'(fade_inc);
    if (fade_sum > int'(FADE_FULL)) fade_sum = int'(FADE_FULL);
    fade = fade_sum[16:0];
    nxt = {1'b0, position} + 21'd1;
    if (nxt >= {1'b0, period}) nxt = '0;
    position = nxt[19:0];
    return r;
  endfunction

  initial begin
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) quarter_wave[k] = quarter_entry(k);
  end

  always @(posedge clk) begin : watch
    tone_sample_t want;
    if (!rst_n) begin
      tone1_inc  = TONE1_STEP_RST;
      tone2_inc  = TONE2_STEP_RST;
      period     = CYCLE_LEN_RST;
      tone_span  = TONE_LEN_RST;
      fade_inc   = FADE_STEP_RST;
      peak       = AMPLITUDE_RST;
      position   = '0;
      phase1     = '0;
      phase2     = '0;
      fade       = '0;
      mismatches = 0;
      expected_samples.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_t'(paddr[4:2]))
          REG_TONE1_STEP: tone1_inc = pwdata;
          REG_TONE2_STEP: tone2_inc = pwdata;
          REG_CYCLE_LEN:  period    = pwdata[19:0];
          REG_TONE_LEN:   tone_span = pwdata[19:0];
          REG_FADE_STEP:  fade_inc  = pwdata[16:0];
          REG_AMPLITUDE:  peak      = pwdata[13:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected transaction: out_sample %0d, out_tone_active %0d",
                 out_sample, out_tone_active);
          mismatches++;
        end else begin
          want = expected_samples.pop_front();
          if (out_sample !== want.sample) begin
            $error("out_sample mismatch: expected %0d, actual %0d", want.sample, out_sample);
            mismatches++;
          end
          if (out_tone_active !== want.tone_active) begin
            $error("out_tone_active mismatch: expected %0d, actual %0d",
                   want.tone_active, out_tone_active);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) expected_samples.push_back(predict_sample(in_restart));
    end
    outstanding <= expected_samples.size();
  end

endmodule

// File: dv/tb_dual_tone_ring_generator.sv
`timescale 1ns / 100ps

module tb_dual_tone_ring_generator;

  import dtrg_pkg::*;

  // DUT inputs, all known from time zero
  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_valid   = 1'b0;
  logic              in_restart = 1'b0;
  logic              out_stall  = 1'b0;
  logic              psel       = 1'b0;
  logic              penable    = 1'b0;
  logic              pwrite     = 1'b0;
  logic [CFG_AW-1:0] paddr      = '0;
  logic [CFG_DW-1:0] pwdata     = '0;

  wire                    in_stall;
  wire                    out_valid;
  wire signed [OUT_W-1:0] out_sample;
  wire                    out_tone_active;
  wire [CFG_DW-1:0]       prdata;
  wire                    pready;

  int mismatches;
  int outstanding;   // ticks accepted but samples not yet seen

  // traffic shaping knobs, changed per phase
  // stall_mode: 0 = sink always ready, 1 = short random stalls, 2 = long stall runs
  // gap_mode:   0 = back-to-back, 1 = short gaps, 2 = long gaps
  int stall_mode = 1;
  int gap_mode   = 1;
  int stall_run  = 0;
  int burst_left = 0;

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  dual_tone_ring_generator u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sample      (out_sample),
    .out_tone_active (out_tone_active),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  dtrg_sample_checker u_sample_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sample      (out_sample),
    .out_tone_active (out_tone_active),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .mismatches      (mismatches),
    .outstanding     (outstanding)
  );

  // Sink back-pressure. Holds each stall level for a random run so that the
  // output register sees both single-cycle blips and long blocks.
  always @(posedge clk) begin
    if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else begin
      case (stall_mode)
        1: begin
          out_stall <= ($urandom_range(0, 3) == 0);
          stall_run <= $urandom_range(0, 2);
        end
        2: begin
          out_stall <= 1'($urandom_range(0, 1));
          stall_run <= $urandom_range(0, 12);
        end
        default: out_stall <= 1'b0;
      endcase
    end
  end

  // One sample-tick transaction. Valid is held until the DUT takes it; the
  // source then either keeps going (rest of the burst) or drops valid for a
  // random gap unless gap_mode is 0. Called at a rising edge.
  task automatic push_tick(input logic restart);
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 10);
      if (gap_mode != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, (gap_mode == 1) ? 3 : 15)) @(posedge clk);
      end
    end
  endtask

  // Stop sending and wait until every predicted sample has come out.
  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready. One idle cycle
  // after so back-to-back writes never touch psel twice in one step.
  task automatic cfg_write(input cfg_reg_t r, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'({r, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_tones(input logic [31:0] t1, input logic [31:0] t2,
                               input logic [19:0] cyc, input logic [19:0] tone,
                               input logic [16:0] fade, input logic [13:0] amp);
    cfg_write(REG_TONE1_STEP, t1);
    cfg_write(REG_TONE2_STEP, t2);
    cfg_write(REG_CYCLE_LEN,  32'(cyc));
    cfg_write(REG_TONE_LEN,   32'(tone));
    cfg_write(REG_FADE_STEP,  32'(fade));
    cfg_write(REG_AMPLITUDE,  32'(amp));
  endtask

  // Random register set. Periods are mostly kept short so the cadence can wrap
  // within a phase; now and then a huge period or a degenerate one.
  task automatic program_random;
    logic [31:0] t1, t2;
    logic [19:0] cyc, tone;
    logic [16:0] fade;
    logic [13:0] amp;
    t1 = $urandom_range(0, 1) ? $urandom_range(20_000_000, 90_000_000) : $urandom();
    t2 = $urandom_range(0, 1) ? $urandom_range(20_000_000, 90_000_000) : $urandom();
    case ($urandom_range(0, 7))
      0:       cyc = 20'($urandom_range(1, 4));
      1:       cyc = 20'($urandom_range(1000, 1048575));
      default: cyc = 20'($urandom_range(20, 400));
    endcase
    case ($urandom_range(0, 5))
      0:       tone = '0;
      1:       tone = 20'(cyc + $urandom_range(0, 50));  // tone outlasts the period
      default: tone = 20'($urandom_range(1, cyc));
    endcase
    case ($urandom_range(0, 4))
      0:       fade = 17'($urandom_range(1, 64));
      1:       fade = 17'($urandom_range(2000, 65536));
      2:       fade = 17'd65536;
      default: fade = 17'($urandom_range(64, 2000));
    endcase
    amp = ($urandom_range(0, 4) == 0) ? 14'd16383 : 14'($urandom_range(0, 16383));
    program_tones(t1, t2, cyc, tone, fade, amp);
  endtask

  initial begin
    int sent;
    int n;
    int phase_no;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed ---
    // Reset defaults; the DUT fills its sine RAM first, so the first tick
    // waits out the fill pass. Restart in the middle rewinds to a fresh
    // burst start.
    push_tick(1'b0);
    push_tick(1'b1);
    push_tick(1'b0);
    drain();

    // Full-scale tone 1 step, zero tone 2 step, tone longer than a 4-sample period,
    // fade jumps straight to saturation, peak amplitude.
    program_tones(32'hFFFF_FFFF, 32'h0, 20'd4, 20'd6, 17'd65536, 14'd16383);
    repeat (6) push_tick(1'b0);
    drain();

    // Zero period: every tick is a cycle start. Zero fade step, zero amplitude.
    program_tones(32'h0, 32'hFFFF_FFFF, 20'd0, 20'd5, 17'd0, 14'd0);
    repeat (3) push_tick(1'b0);
    drain();

    // Maximum period and tone length, fade step stuck at zero: active but mute.
    program_tones(32'd39370534, 32'd42949673, 20'hFFFFF, 20'hFFFFF, 17'd0, 14'd16383);
    repeat (3) push_tick(1'b0);
    drain();

    // Walk the position up, then shrink the period below it: the next tick
    // has to fold back to a cycle start.
    program_tones(32'd60000000, 32'd70000000, 20'd1000, 20'd1000, 17'd1, 14'd12000);
    repeat (6) push_tick(1'b0);
    drain();
    cfg_write(REG_CYCLE_LEN, 32'd3);
    cfg_write(REG_TONE_LEN,  32'd2);
    push_tick(1'b0);
    push_tick(1'b1);
    push_tick(1'b0);
    drain();

    // --- random phases ---
    sent     = 24;    // directed ticks above
    phase_no = 0;
    while (sent < 1050) begin
      drain();
      program_random();
      stall_mode = $urandom_range(0, 2);
      gap_mode   = $urandom_range(0, 2);
      n = $urandom_range(40, 120);
      if (n > 1050 - sent) n = 1050 - sent;
      for (int i = 0; i < n; i++) begin
        // one mid-phase pause with the pipe fully emptied, config untouched
        if (phase_no == 2 && i == n / 2) drain();
        push_tick($urandom_range(0, 31) == 0);
      end
      sent += n;
      phase_no++;
    end

    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog: fill pass plus the whole run, many times over
  initial begin
    #(12 * 1_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/dtrg_pkg.sv
hw/rtl/dtrg_ram.sv
hw/rtl/dual_tone_ring_generator.sv
hw/rtl/dtrg_checker.sv
dv/dtrg_sample_checker.sv
dv/tb_dual_tone_ring_generator.sv
